### sv/mrrd_pkg.sv
// Shared constants and types for the Modbus RTU reply deframer.
`default_nettype none

package mrrd_pkg;

  // Longest frame that the block will ever accept, in bytes.
  localparam int unsigned MAX_FRAME = 256;
  localparam int unsigned MIN_FRAME = 5;

  localparam int unsigned CFG_W   = 9;                       // max_frame_len register
  localparam int unsigned LEN_W   = $clog2(MAX_FRAME + 262); // computed length, with headroom
  localparam int unsigned CNT_W   = $clog2(MAX_FRAME + 1);   // byte counter
  localparam int unsigned POS_W   = 8;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CRC_W   = 16;
  localparam int unsigned STAT_W  = 3;

  // APB port
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 3;

  // Register indexes (word address paddr[2])
  localparam logic REG_MAX_FRAME_LEN = 1'b0;

  localparam logic [CFG_W-1:0] MAX_FRAME_LEN_RST = CFG_W'(256);

  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
  localparam logic [CRC_W-1:0] CRC_SEED = 16'hFFFF;

  // Function codes with a length rule
  localparam logic [BYTE_W-1:0] FC_READ_HOLD  = 8'h03;
  localparam logic [BYTE_W-1:0] FC_READ_INPUT = 8'h04;
  localparam logic [BYTE_W-1:0] FC_WRITE_SGL  = 8'h06;
  localparam logic [BYTE_W-1:0] FC_DIAG       = 8'h08;
  localparam logic [BYTE_W-1:0] FC_EXCEPTION  = 8'h80;

  localparam logic [LEN_W-1:0] LEN_READ_EXTRA = LEN_W'(5);
  localparam logic [LEN_W-1:0] LEN_FIXED      = LEN_W'(8);
  localparam logic [LEN_W-1:0] LEN_EXCEPTION  = LEN_W'(5);

  typedef enum logic [STAT_W-1:0] {
    ST_BUSY    = 3'd0,
    ST_OK      = 3'd1,
    ST_CRC     = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_TOOLONG = 3'd4
  } status_e;

endpackage

`default_nettype wire

### sv/mrrd_if.sv
// Valid/ready channel interfaces for received bytes and per-byte results.
`default_nettype none

interface mrrd_rx_if;
  logic                          valid;
  logic                          ready;
  logic [mrrd_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mrrd_res_if;
  logic                          valid;
  logic                          ready;
  logic [mrrd_pkg::BYTE_W-1:0]   byte_echo;
  logic [mrrd_pkg::POS_W-1:0]    byte_position;
  logic                          frame_end;
  logic [mrrd_pkg::STAT_W-1:0]   frame_status;

  modport source (output valid, output byte_echo, output byte_position,
                  output frame_end, output frame_status, input ready);
  modport sink   (input valid, input byte_echo, input byte_position,
                  input frame_end, input frame_status, output ready);
endinterface

`default_nettype wire

### sv/modbus_rtu_reply_deframer_unit.sv
// Modbus RTU reply deframer: per-byte framing, length rules and CRC-16 check.
`default_nettype none

// Takes reply bytes on rx_i and returns one result per byte on res_o: the byte, its
// position in the frame, a frame-end flag and a status (in progress, ok, CRC error,
// unknown function, too long). The third byte fixes the frame length from the
// function code; the last two bytes are checked against the running CRC-16/Modbus,
// low byte first. A byte is taken every cycle while results drain: it sits in an
// input register, the length decode and the eight-bit CRC update run in a single
// pass between that register and the result register, so the result is registered
// and the sustained rate is one byte per cycle. The max_frame_len register
// lies at APB address 0 and is clamped to 5..256 when used; write it between frames.
module modbus_rtu_reply_deframer_unit (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  mrrd_rx_if.sink                          rx_i,
  mrrd_res_if.source                       res_o,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [mrrd_pkg::APB_AW-1:0]      paddr,
  input  wire  [mrrd_pkg::APB_DW-1:0]      pwdata,
  output logic [mrrd_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);

  function automatic logic [mrrd_pkg::CRC_W-1:0] crc_byte(
    input logic [mrrd_pkg::CRC_W-1:0]  crc,
    input logic [mrrd_pkg::BYTE_W-1:0] b
  );
    logic [mrrd_pkg::CRC_W-1:0] c;
    c = crc ^ {{(mrrd_pkg::CRC_W-mrrd_pkg::BYTE_W){1'b0}}, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ mrrd_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Configuration
  logic [mrrd_pkg::CFG_W-1:0] max_len_q;
  logic                       cfg_wr;
  logic [mrrd_pkg::LEN_W-1:0] limit;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == mrrd_pkg::REG_MAX_FRAME_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= mrrd_pkg::MAX_FRAME_LEN_RST;
    end else if (cfg_wr) begin
      max_len_q <= pwdata[mrrd_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == mrrd_pkg::REG_MAX_FRAME_LEN) begin
      prdata = mrrd_pkg::APB_DW'(max_len_q);
    end
  end

  always_comb begin
    limit = mrrd_pkg::LEN_W'(max_len_q);
    if (limit < mrrd_pkg::LEN_W'(mrrd_pkg::MIN_FRAME)) begin
      limit = mrrd_pkg::LEN_W'(mrrd_pkg::MIN_FRAME);
    end
    if (limit > mrrd_pkg::LEN_W'(mrrd_pkg::MAX_FRAME)) begin
      limit = mrrd_pkg::LEN_W'(mrrd_pkg::MAX_FRAME);
    end
  end

  // Input register and handshake
  logic                        in_valid_q;
  logic [mrrd_pkg::BYTE_W-1:0] in_byte_q;
  logic                        out_valid_q;
  logic                        adv;
  logic                        in_ready;

  assign adv      = in_valid_q && (!out_valid_q || res_o.ready);
  assign in_ready = !in_valid_q || adv;
  assign rx_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  // Frame state
  logic [mrrd_pkg::CNT_W-1:0]  count_q, count_d;
  logic [mrrd_pkg::LEN_W-1:0]  exp_q, exp_d;
  logic [mrrd_pkg::CRC_W-1:0]  crc_q, crc_d;
  logic [mrrd_pkg::BYTE_W-1:0] fc_q, fc_d;
  logic [mrrd_pkg::BYTE_W-1:0] crc_lo_q, crc_lo_d;

  logic [mrrd_pkg::LEN_W-1:0]  len;
  logic [mrrd_pkg::LEN_W-1:0]  pos_p2;
  logic                        done;
  mrrd_pkg::status_e           status;

  always_comb begin
    fc_d     = fc_q;
    exp_d    = exp_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    len      = '0;
    done     = 1'b0;
    status   = mrrd_pkg::ST_BUSY;
    pos_p2   = mrrd_pkg::LEN_W'(count_q) + mrrd_pkg::LEN_W'(2);

    if (count_q == mrrd_pkg::CNT_W'(1)) begin
      fc_d = in_byte_q;
    end

    // Length rule from the function code at the byte-count byte
    if (count_q == mrrd_pkg::CNT_W'(2)) begin
      if (fc_q == mrrd_pkg::FC_READ_HOLD || fc_q == mrrd_pkg::FC_READ_INPUT) begin
        len = mrrd_pkg::LEN_W'(in_byte_q) + mrrd_pkg::LEN_READ_EXTRA;
      end else if (fc_q == mrrd_pkg::FC_WRITE_SGL || fc_q == mrrd_pkg::FC_DIAG) begin
        len = mrrd_pkg::LEN_FIXED;
      end else if (fc_q >= mrrd_pkg::FC_EXCEPTION) begin
        len = mrrd_pkg::LEN_EXCEPTION;
      end else begin
        status = mrrd_pkg::ST_UNKNOWN;
        done   = 1'b1;
      end
      if (!done) begin
        if (len > limit) begin
          status = mrrd_pkg::ST_TOOLONG;
          done   = 1'b1;
        end else begin
          exp_d = len;
        end
      end
    end

    // Header bytes always go into the CRC; later ones follow the expected length
    if (!done) begin
      if (count_q < mrrd_pkg::CNT_W'(2) || pos_p2 < exp_d) begin
        crc_d = crc_byte(crc_q, in_byte_q);
      end else if (pos_p2 == exp_d) begin
        crc_lo_d = in_byte_q;
      end else begin
        done   = 1'b1;
        status = (crc_lo_q == crc_q[7:0] && in_byte_q == crc_q[15:8]) ?
                 mrrd_pkg::ST_OK : mrrd_pkg::ST_CRC;
      end
    end

    count_d = count_q + mrrd_pkg::CNT_W'(1);
    if (done) begin
      count_d  = '0;
      exp_d    = limit;
      crc_d    = mrrd_pkg::CRC_SEED;
      fc_d     = '0;
      crc_lo_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      exp_q    <= mrrd_pkg::LEN_W'(mrrd_pkg::MAX_FRAME);
      crc_q    <= mrrd_pkg::CRC_SEED;
      fc_q     <= '0;
      crc_lo_q <= '0;
    end else if (adv) begin
      count_q  <= count_d;
      exp_q    <= exp_d;
      crc_q    <= crc_d;
      fc_q     <= fc_d;
      crc_lo_q <= crc_lo_d;
    end
  end

  // Result register
  logic [mrrd_pkg::BYTE_W-1:0] out_byte_q;
  logic [mrrd_pkg::POS_W-1:0]  out_pos_q;
  logic                        out_end_q;
  logic [mrrd_pkg::STAT_W-1:0] out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_q   <= in_byte_q;
      out_pos_q    <= mrrd_pkg::POS_W'(count_q);
      out_end_q    <= done;
      out_status_q <= status;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.byte_echo     = out_byte_q;
  assign res_o.byte_position = out_pos_q;
  assign res_o.frame_end     = out_end_q;
  assign res_o.frame_status  = out_status_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < mrrd_pkg::CNT_W'(mrrd_pkg::MAX_FRAME))
    else $error("byte counter ran past the longest frame");

  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && done |=> count_q == '0 && crc_q == mrrd_pkg::CRC_SEED)
    else $error("frame end did not restart the frame state");

  a_seed_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> crc_q == mrrd_pkg::CRC_SEED)
    else $error("CRC not seeded at frame start");

  a_end_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_end_q == (out_status_q != mrrd_pkg::ST_BUSY)))
    else $error("frame end flag disagrees with status");

endmodule

`default_nettype wire

### sim/modbus_rtu_reply_deframer_unit_test.sv
// Self-checking testbench for the Modbus RTU reply deframer: frame stimulus and result checks.
module modbus_rtu_reply_deframer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 400_000;
  localparam int unsigned SEGMENT_BYTES = 250;
  localparam int unsigned REPORT_CAP    = 40;

  typedef enum int unsigned {
    PACE_SEND_SPARSE,   // sender idles 27 %, receiver 78 %
    PACE_RECV_SPARSE,   // sender idles 78 %, receiver 27 %
    PACE_FREE
  } pace_e;

  typedef struct packed {
    logic [mrrd_pkg::BYTE_W-1:0] byte_echo;
    logic [mrrd_pkg::POS_W-1:0]  byte_position;
    logic                        frame_end;
    mrrd_pkg::status_e           frame_status;
  } byte_result_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [mrrd_pkg::APB_AW-1:0]   paddr;
  logic [mrrd_pkg::APB_DW-1:0]   pwdata;
  logic [mrrd_pkg::APB_DW-1:0]   prdata;
  logic                          pready;

  mrrd_rx_if  rx_bytes ();
  mrrd_res_if byte_results ();

  modbus_rtu_reply_deframer_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_bytes),
    .res_o   (byte_results),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Byte stream waiting to be offered, and results still owed by the block
  logic [mrrd_pkg::BYTE_W-1:0] pending_bytes[$];
  byte_result_t                expected_results[$];
  int unsigned                 queued_bytes = 0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned results_hold_left = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Deframer state as the predictor sees it
  logic [mrrd_pkg::CFG_W-1:0]  cfg_max_len;
  int unsigned                 rx_count;
  int unsigned                 frame_len;
  logic [mrrd_pkg::CRC_W-1:0]  crc_acc;
  logic [mrrd_pkg::BYTE_W-1:0] func_code;
  logic [mrrd_pkg::BYTE_W-1:0] crc_lo;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned frame_limit();
    int unsigned m = cfg_max_len;
    if (m < mrrd_pkg::MIN_FRAME) m = mrrd_pkg::MIN_FRAME;
    if (m > mrrd_pkg::MAX_FRAME) m = mrrd_pkg::MAX_FRAME;
    return m;
  endfunction

  function automatic logic [mrrd_pkg::CRC_W-1:0] crc16_step(
    input logic [mrrd_pkg::CRC_W-1:0]  c,
    input logic [mrrd_pkg::BYTE_W-1:0] b
  );
    logic [mrrd_pkg::CRC_W-1:0] acc;
    acc = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      acc = acc[0] ? ((acc >> 1) ^ mrrd_pkg::CRC_POLY) : (acc >> 1);
    end
    return acc;
  endfunction

  function automatic void start_frame();
    rx_count  = 0;
    frame_len = frame_limit();
    crc_acc   = mrrd_pkg::CRC_SEED;
    func_code = '0;
    crc_lo    = '0;
  endfunction

  function automatic void predict_byte(input logic [mrrd_pkg::BYTE_W-1:0] b);
    byte_result_t      r;
    int unsigned       pos;
    int unsigned       len;
    logic              done;
    mrrd_pkg::status_e st;
    pos  = rx_count;
    len  = 0;
    done = 1'b0;
    st   = mrrd_pkg::ST_BUSY;
    if (pos == 1) func_code = b;
    // third byte fixes the length or ends the frame
    if (pos == 2) begin
      if (func_code == mrrd_pkg::FC_READ_HOLD || func_code == mrrd_pkg::FC_READ_INPUT) begin
        len = b + mrrd_pkg::LEN_READ_EXTRA;
      end else if (func_code == mrrd_pkg::FC_WRITE_SGL || func_code == mrrd_pkg::FC_DIAG) begin
        len = mrrd_pkg::LEN_FIXED;
      end else if (func_code >= mrrd_pkg::FC_EXCEPTION) begin
        len = mrrd_pkg::LEN_EXCEPTION;
      end else begin
        st   = mrrd_pkg::ST_UNKNOWN;
        done = 1'b1;
      end
      if (!done) begin
        if (len > frame_limit()) begin
          st   = mrrd_pkg::ST_TOOLONG;
          done = 1'b1;
        end else begin
          frame_len = len;
        end
      end
    end
    if (!done) begin
      if (pos + 2 < frame_len) begin
        crc_acc = crc16_step(crc_acc, b);
      end else if (pos + 2 == frame_len) begin
        crc_lo = b;
      end else begin
        st   = (crc_lo == crc_acc[7:0] && b == crc_acc[15:8]) ?
               mrrd_pkg::ST_OK : mrrd_pkg::ST_CRC;
        done = 1'b1;
      end
    end
    r.byte_echo     = b;
    r.byte_position = pos[mrrd_pkg::POS_W-1:0];
    r.frame_end     = done;
    r.frame_status  = st;
    expected_results.push_back(r);
    if (done) start_frame();
    else rx_count = (pos + 1) & 32'h1FF;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < REPORT_CAP) begin
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic check_result();
    byte_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing pending", byte_results.byte_echo, -1);
    end else begin
      want = expected_results.pop_front();
      if (byte_results.byte_echo !== want.byte_echo)
        report_mismatch("byte_echo", byte_results.byte_echo, want.byte_echo);
      if (byte_results.byte_position !== want.byte_position)
        report_mismatch("byte_position", byte_results.byte_position, want.byte_position);
      if (byte_results.frame_end !== want.frame_end)
        report_mismatch("frame_end", byte_results.frame_end, want.frame_end);
      if (byte_results.frame_status !== want.frame_status)
        report_mismatch("frame_status", byte_results.frame_status, want.frame_status);
    end
  endtask

  // Driver: offer the next pending byte, predict on every accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_bytes.valid   <= 1'b0;
      rx_bytes.rx_byte <= '0;
    end else begin
      if (rx_bytes.valid && rx_bytes.ready) predict_byte(rx_bytes.rx_byte);
      if (!rx_bytes.valid || rx_bytes.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          rx_bytes.valid   <= 1'b1;
          rx_bytes.rx_byte <= pending_bytes.pop_front();
        end else begin
          rx_bytes.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result, stall at random or while held off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_results.ready <= 1'b0;
    end else begin
      if (byte_results.valid && byte_results.ready) check_result();
      byte_results.ready <= (results_hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long receiver hold-off, counted down here
  always @(posedge clk_i) begin
    if (results_hold_left != 0) results_hold_left <= results_hold_left - 1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_byte(input logic [mrrd_pkg::BYTE_W-1:0] b);
    pending_bytes.push_back(b);
    queued_bytes++;
  endtask

  // Append the CRC, low byte first; optionally damage one of its bytes
  task automatic queue_frame(input logic [mrrd_pkg::BYTE_W-1:0] body[$], input bit spoil_crc);
    logic [mrrd_pkg::CRC_W-1:0] c;
    int unsigned                idx;
    c = mrrd_pkg::CRC_SEED;
    foreach (body[i]) c = crc16_step(c, body[i]);
    body.push_back(c[7:0]);
    body.push_back(c[15:8]);
    if (spoil_crc) begin
      idx = $urandom_range(body.size() - 1, body.size() - 2);
      body[idx] = body[idx] ^ (8'h01 << $urandom_range(7));
    end
    foreach (body[i]) push_byte(body[i]);
  endtask

  task automatic queue_random_frame();
    logic [mrrd_pkg::BYTE_W-1:0] body[$];
    logic [mrrd_pkg::BYTE_W-1:0] fc;
    int unsigned                 lim;
    int unsigned                 kind;
    int unsigned                 n;
    int unsigned                 r;
    lim  = frame_limit();
    kind = $urandom_range(99);
    body.push_back(mrrd_pkg::BYTE_W'($urandom_range(255)));
    if (kind < 80) begin
      case ($urandom_range(2))
        0: begin
          fc = $urandom_range(1) ? mrrd_pkg::FC_READ_HOLD : mrrd_pkg::FC_READ_INPUT;
          // mostly short payloads, now and then the longest that fits
          r = $urandom_range(99);
          if (r < 3) n = lim - mrrd_pkg::MIN_FRAME;
          else if (r < 10) n = $urandom_range(lim - mrrd_pkg::MIN_FRAME);
          else n = $urandom_range((lim - mrrd_pkg::MIN_FRAME) < 12 ?
                                  (lim - mrrd_pkg::MIN_FRAME) : 12);
          body.push_back(fc);
          body.push_back(mrrd_pkg::BYTE_W'(n));
          repeat (n) body.push_back(mrrd_pkg::BYTE_W'($urandom_range(255)));
        end
        1: begin
          body.push_back($urandom_range(1) ? mrrd_pkg::FC_WRITE_SGL : mrrd_pkg::FC_DIAG);
          repeat (4) body.push_back(mrrd_pkg::BYTE_W'($urandom_range(255)));
        end
        default: begin
          body.push_back(mrrd_pkg::BYTE_W'($urandom_range(255, mrrd_pkg::FC_EXCEPTION)));
          body.push_back(mrrd_pkg::BYTE_W'($urandom_range(255)));
        end
      endcase
      queue_frame(body, kind >= 70);
    end else if (kind < 90) begin
      do fc = mrrd_pkg::BYTE_W'($urandom_range(mrrd_pkg::FC_EXCEPTION - 1));
      while (fc == mrrd_pkg::FC_READ_HOLD || fc == mrrd_pkg::FC_READ_INPUT ||
             fc == mrrd_pkg::FC_WRITE_SGL || fc == mrrd_pkg::FC_DIAG);
      push_byte(body[0]);
      push_byte(fc);
      push_byte(mrrd_pkg::BYTE_W'($urandom_range(255)));
    end else if (kind < 95) begin
      push_byte(body[0]);
      push_byte($urandom_range(1) ? mrrd_pkg::FC_READ_HOLD : mrrd_pkg::FC_READ_INPUT);
      push_byte(mrrd_pkg::BYTE_W'($urandom_range(255, lim - mrrd_pkg::MIN_FRAME + 1)));
    end else begin
      repeat ($urandom_range(6, 1)) push_byte(mrrd_pkg::BYTE_W'($urandom_range(255)));
    end
  endtask

  task automatic set_pace(input pace_e mode);
    case (mode)
      PACE_SEND_SPARSE: begin
        send_idle_pct = 27;
        recv_idle_pct = 78;
      end
      PACE_RECV_SPARSE: begin
        send_idle_pct = 78;
        recv_idle_pct = 27;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  task automatic write_max_frame_len(input logic [mrrd_pkg::CFG_W-1:0] value);
    logic [mrrd_pkg::APB_DW-1:0] word;
    word = $urandom();
    word[mrrd_pkg::CFG_W-1:0] = value;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {mrrd_pkg::REG_MAX_FRAME_LEN, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_max_len = value;
    @(negedge clk_i);
  endtask

  // Wait until every byte is taken and every result has come back
  task automatic drain();
    while (pending_bytes.size() != 0 || rx_bytes.valid) @(negedge clk_i);
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_segment();
    int unsigned start;
    start = queued_bytes;
    while (queued_bytes - start < SEGMENT_BYTES) queue_random_frame();
    drain();
  endtask

  initial begin
    logic [mrrd_pkg::BYTE_W-1:0] frame[$];
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    rx_bytes.valid     = 1'b0;
    rx_bytes.rx_byte   = '0;
    byte_results.ready = 1'b0;
    cfg_max_len        = mrrd_pkg::MAX_FRAME_LEN_RST;
    start_frame();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_pace(PACE_SEND_SPARSE);
    // exception, diagnostic, damaged check, unknown code, over-long count
    frame = '{8'hFF, mrrd_pkg::FC_EXCEPTION, 8'hFF};
    queue_frame(frame, 1'b0);
    frame = '{8'h00, mrrd_pkg::FC_DIAG, 8'hFF, 8'h00, 8'hFF, 8'h00};
    queue_frame(frame, 1'b0);
    frame = '{8'h55, mrrd_pkg::FC_READ_INPUT, 8'h00};
    queue_frame(frame, 1'b1);
    push_byte(8'hAA);
    push_byte(mrrd_pkg::BYTE_W'(mrrd_pkg::FC_EXCEPTION - 1));
    push_byte(8'h00);
    push_byte(8'h01);
    push_byte(mrrd_pkg::FC_READ_HOLD);
    push_byte(8'hFF);
    drain();
    run_segment();
    write_max_frame_len(mrrd_pkg::CFG_W'(mrrd_pkg::MIN_FRAME));
    run_segment();

    set_pace(PACE_RECV_SPARSE);
    write_max_frame_len('1);
    run_segment();
    write_max_frame_len('0);
    run_segment();
    write_max_frame_len(mrrd_pkg::CFG_W'(12));
    run_segment();

    set_pace(PACE_FREE);
    write_max_frame_len(mrrd_pkg::CFG_W'(mrrd_pkg::MAX_FRAME + 1));
    // hold results off while the sender keeps offering, so the input backs up
    while (queued_bytes < 1500) queue_random_frame();
    results_hold_left = 400;
    while (results_hold_left != 0) @(negedge clk_i);
    drain();
    write_max_frame_len(mrrd_pkg::CFG_W'($urandom_range(mrrd_pkg::MAX_FRAME,
                                                        mrrd_pkg::MIN_FRAME)));
    run_segment();
    write_max_frame_len(mrrd_pkg::CFG_W'(mrrd_pkg::MAX_FRAME - 1));
    run_segment();

    repeat (10) @(negedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", 0, expected_results.size());
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
